// ===== rtl/gbn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the go-back-n sender: command and result codes, controller
// states, and the command/status structs between controller and datapath.
// No dependencies.
package gbn_pkg;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_TX      = 3'd0,
        KIND_REFUSED = 3'd1,
        KIND_TSTART  = 3'd2,
        KIND_TSTOP   = 3'd3,
        KIND_CORRUPT = 3'd4,
        KIND_OUTSIDE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_NEXT_M1,
        SEQ_BASE,
        SEQ_ACK,
        SEQ_EXP,
        SEQ_RETX
    } seq_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_SEND_START,
        ST_ACK,
        ST_ACK_START,
        ST_TO_STOP,
        ST_TO_TX,
        ST_TO_START
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic     latch;
        logic     emit;
        kind_t    kind;
        seq_sel_t seq_sel;
        logic     data_pay;
        logic     data_ram;
        logic     last;
        logic     do_send;
        logic     do_retire;
        logic     rd_first;
        logic     rd_step;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic ck_ok;
        logic in_window;
        logic remain_zero;
        logic out_zero;
        logic retx_last;
    } status_t;

endpackage

// ===== rtl/gbn_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gbn_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the go-back-n sender: window pointers, sequence counters, the
// window size register, latched command fields and the payload RAM.
// Depends on gbn_pkg and gbn_ram.
module gbn_datapath #(
    parameter int MAX_WINDOW   = 8,
    parameter int SEQ_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbn_pkg::ctrl_t          ctrl,
    output gbn_pkg::status_t        status,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic [SEQ_BITS-1:0]     ack_number,
    input  logic                    ack_checksum_ok,
    input  logic [SEQ_BITS-1:0]     expired_timer_seq,
    input  logic                    cfg_we,
    input  logic [3:0]              cfg_data,
    output logic [SEQ_BITS-1:0]     seq,
    output logic [PAYLOAD_BITS-1:0] data
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int EW    = (CNT_W > 4) ? CNT_W : 4;
    localparam int CW    = SEQ_BITS + CNT_W;

    logic [SEQ_BITS-1:0]     base_reg, base_next;
    logic [SEQ_BITS-1:0]     next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]        outstanding_reg, outstanding_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [3:0]              wsize_reg, wsize_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [SEQ_BITS-1:0]     ack_reg;
    logic                    ck_reg;
    logic [SEQ_BITS-1:0]     exp_reg;

    logic [SEQ_BITS-1:0]     ack_off;
    logic [CNT_W-1:0]        retire;
    logic [EW-1:0]           eff_window;
    logic [IDX_W-1:0]        wr_slot;
    logic [IDX_W-1:0]        rd_slot;
    logic [PAYLOAD_BITS-1:0] rd_data;

    // ring slot at an offset from the head; offset never exceeds MAX_WINDOW
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_WINDOW))
        begin
            sum = sum - SUM_W'(MAX_WINDOW);
        end
        return IDX_W'(sum);
    endfunction

    always_comb
    begin
        if (wsize_reg == 4'd0)
        begin
            eff_window = EW'(1);
        end
        else if (EW'(wsize_reg) > EW'(MAX_WINDOW))
        begin
            eff_window = EW'(MAX_WINDOW);
        end
        else
        begin
            eff_window = EW'(wsize_reg);
        end
    end

    assign ack_off = ack_reg - base_reg;
    assign retire  = CNT_W'(ack_off) + CNT_W'(1);
    assign wr_slot = slot_of(head_reg, outstanding_reg);
    assign rd_slot = ctrl.rd_first ? head_reg : slot_of(head_reg, idx_reg + CNT_W'(1));

    always_comb
    begin
        status.full        = EW'(outstanding_reg) >= eff_window;
        status.ck_ok       = ck_reg;
        status.in_window   = CW'(ack_off) < CW'(outstanding_reg);
        status.remain_zero = (CW'(ack_off) + CW'(1)) == CW'(outstanding_reg);
        status.out_zero    = outstanding_reg == '0;
        status.retx_last   = (SUM_W'(idx_reg) + SUM_W'(1)) == SUM_W'(outstanding_reg);
    end

    always_comb
    begin
        base_next        = base_reg;
        next_seq_next    = next_seq_reg;
        outstanding_next = outstanding_reg;
        head_next        = head_reg;
        wsize_next       = cfg_we ? cfg_data : wsize_reg;
        idx_next         = idx_reg;
        if (ctrl.do_send)
        begin
            outstanding_next = outstanding_reg + CNT_W'(1);
            next_seq_next    = next_seq_reg + SEQ_BITS'(1);
        end
        if (ctrl.do_retire)
        begin
            head_next        = slot_of(head_reg, retire);
            outstanding_next = outstanding_reg - retire;
            base_next        = ack_reg + SEQ_BITS'(1);
        end
        if (ctrl.rd_first)
        begin
            idx_next = '0;
        end
        else if (ctrl.rd_step)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= SEQ_BITS'(1);
            next_seq_reg    <= SEQ_BITS'(1);
            outstanding_reg <= '0;
            head_reg        <= '0;
            wsize_reg       <= 4'd5;
            idx_reg         <= '0;
        end
        else
        begin
            base_reg        <= base_next;
            next_seq_reg    <= next_seq_next;
            outstanding_reg <= outstanding_next;
            head_reg        <= head_next;
            wsize_reg       <= wsize_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            pay_reg <= payload;
            ack_reg <= ack_number;
            ck_reg  <= ack_checksum_ok;
            exp_reg <= expired_timer_seq;
        end
    end

    gbn_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.do_send),
        .waddr (wr_slot),
        .wdata (pay_reg),
        .re    (ctrl.rd_first | ctrl.rd_step),
        .raddr (rd_slot),
        .rdata (rd_data)
    );

    always_comb
    begin
        case (ctrl.seq_sel)
            gbn_pkg::SEQ_NEXT:    seq = next_seq_reg;
            gbn_pkg::SEQ_NEXT_M1: seq = next_seq_reg - SEQ_BITS'(1);
            gbn_pkg::SEQ_BASE:    seq = base_reg;
            gbn_pkg::SEQ_ACK:     seq = ack_reg;
            gbn_pkg::SEQ_EXP:     seq = exp_reg;
            gbn_pkg::SEQ_RETX:    seq = base_reg + SEQ_BITS'(idx_reg);
            default:              seq = '0;
        endcase
    end

    always_comb
    begin
        if (ctrl.data_pay)
        begin
            data = pay_reg;
        end
        else if (ctrl.data_ram)
        begin
            data = rd_data;
        end
        else
        begin
            data = '0;
        end
    end

endmodule

// ===== rtl/gbn_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the go-back-n sender: sequences the results of
// each command and issues datapath commands one result per cycle.
// Depends on gbn_pkg.
module gbn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  gbn_pkg::cmd_t      cmd,
    input  gbn_pkg::status_t   status,
    output gbn_pkg::ctrl_t     ctrl,
    output logic               busy
);

    gbn_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            gbn_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        gbn_pkg::CMD_SEND:    state_next = gbn_pkg::ST_SEND;
                        gbn_pkg::CMD_ACK:     state_next = gbn_pkg::ST_ACK;
                        gbn_pkg::CMD_TIMEOUT: state_next = gbn_pkg::ST_TO_STOP;
                        default:              state_next = gbn_pkg::ST_IDLE;
                    endcase
                end
            end
            gbn_pkg::ST_SEND:
            begin
                if (!status.full && status.out_zero)
                begin
                    state_next = gbn_pkg::ST_SEND_START;
                end
                else
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            gbn_pkg::ST_ACK:
            begin
                if (status.ck_ok && status.in_window && !status.remain_zero)
                begin
                    state_next = gbn_pkg::ST_ACK_START;
                end
                else
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            gbn_pkg::ST_TO_STOP:
            begin
                state_next = status.out_zero ? gbn_pkg::ST_TO_START : gbn_pkg::ST_TO_TX;
            end
            gbn_pkg::ST_TO_TX:
            begin
                state_next = status.retx_last ? gbn_pkg::ST_TO_START : gbn_pkg::ST_TO_TX;
            end
            gbn_pkg::ST_SEND_START,
            gbn_pkg::ST_ACK_START,
            gbn_pkg::ST_TO_START:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg) inside
            gbn_pkg::ST_IDLE:
            begin
                ctrl.latch = start;
            end
            gbn_pkg::ST_SEND:
            begin
                ctrl.emit    = 1'b1;
                ctrl.seq_sel = gbn_pkg::SEQ_NEXT;
                if (status.full)
                begin
                    ctrl.kind = gbn_pkg::KIND_REFUSED;
                    ctrl.last = 1'b1;
                end
                else
                begin
                    ctrl.kind     = gbn_pkg::KIND_TX;
                    ctrl.data_pay = 1'b1;
                    ctrl.do_send  = 1'b1;
                    ctrl.last     = !status.out_zero;
                end
            end
            gbn_pkg::ST_SEND_START:
            begin
                // next_seq already advanced past the packet just sent
                ctrl.emit    = 1'b1;
                ctrl.kind    = gbn_pkg::KIND_TSTART;
                ctrl.seq_sel = gbn_pkg::SEQ_NEXT_M1;
                ctrl.last    = 1'b1;
            end
            gbn_pkg::ST_ACK:
            begin
                ctrl.emit = 1'b1;
                if (!status.ck_ok)
                begin
                    ctrl.kind    = gbn_pkg::KIND_CORRUPT;
                    ctrl.seq_sel = gbn_pkg::SEQ_ACK;
                    ctrl.last    = 1'b1;
                end
                else if (!status.in_window)
                begin
                    ctrl.kind    = gbn_pkg::KIND_OUTSIDE;
                    ctrl.seq_sel = gbn_pkg::SEQ_ACK;
                    ctrl.last    = 1'b1;
                end
                else
                begin
                    ctrl.kind      = gbn_pkg::KIND_TSTOP;
                    ctrl.seq_sel   = gbn_pkg::SEQ_BASE;
                    ctrl.do_retire = 1'b1;
                    ctrl.last      = status.remain_zero;
                end
            end
            gbn_pkg::ST_ACK_START,
            gbn_pkg::ST_TO_START:
            begin
                ctrl.emit    = 1'b1;
                ctrl.kind    = gbn_pkg::KIND_TSTART;
                ctrl.seq_sel = gbn_pkg::SEQ_BASE;
                ctrl.last    = 1'b1;
            end
            gbn_pkg::ST_TO_STOP:
            begin
                // fetch the oldest payload while the stop goes out
                ctrl.emit     = 1'b1;
                ctrl.kind     = gbn_pkg::KIND_TSTOP;
                ctrl.seq_sel  = gbn_pkg::SEQ_EXP;
                ctrl.rd_first = 1'b1;
            end
            gbn_pkg::ST_TO_TX:
            begin
                ctrl.emit     = 1'b1;
                ctrl.kind     = gbn_pkg::KIND_TX;
                ctrl.seq_sel  = gbn_pkg::SEQ_RETX;
                ctrl.data_ram = 1'b1;
                ctrl.rd_step  = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign busy = state_reg != gbn_pkg::ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a send always answers in the cycle after its transfer
    a_send_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbn_pkg::ST_IDLE && start && cmd == gbn_pkg::CMD_SEND)
        |=> ctrl.emit)
        else $error("send transfer not answered in next cycle");

    // the final result of an item returns the controller to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.last) |=> state_reg == gbn_pkg::ST_IDLE)
        else $error("controller not idle after final result");

    // retransmit data must come from a read issued the cycle before
    a_retx_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbn_pkg::ST_TO_TX) |-> $past(ctrl.rd_first || ctrl.rd_step))
        else $error("retransmit without prior store read");

    // no result while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> !ctrl.emit)
        else $error("result strobe while idle");

endmodule

// ===== rtl/go_back_n_sender_unit.sv =====
`timescale 1ns / 1ps
// Go-back-n sender: a command is transferred when start is high and busy is low;
// its results leave one per cycle on result_valid with last on the final one.
// The receiver cannot stall the result stream, so every result_valid cycle is a
// transfer. A send or an acknowledgement gives one result, then a timer start
// when the timer is also started. A timeout gives a timer stop, a retransmission
// of each outstanding packet and a timer start; the controller walks the payload
// RAM through its single read port one packet per cycle. An unused command gives
// no result. busy stays high until the last result has gone out. The window size
// register is written through cfg_valid/cfg_ready, which is always ready.
// Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
module go_back_n_sender_unit #(
    parameter int MAX_WINDOW   = 8,
    parameter int SEQ_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              cmd,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic [SEQ_BITS-1:0]     ack_number,
    input  logic                    ack_checksum_ok,
    input  logic [SEQ_BITS-1:0]     expired_timer_seq,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [3:0]              cfg_data,
    output logic                    result_valid,
    output logic [2:0]              kind,
    output logic [SEQ_BITS-1:0]     seq,
    output logic [PAYLOAD_BITS-1:0] data,
    output logic                    last
);

    gbn_pkg::ctrl_t   ctrl;
    gbn_pkg::status_t status;

    gbn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (gbn_pkg::cmd_t'(cmd)),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    gbn_datapath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .status            (status),
        .payload           (payload),
        .ack_number        (ack_number),
        .ack_checksum_ok   (ack_checksum_ok),
        .expired_timer_seq (expired_timer_seq),
        .cfg_we            (cfg_valid & cfg_ready),
        .cfg_data          (cfg_data),
        .seq               (seq),
        .data              (data)
    );

    assign cfg_ready    = 1'b1;
    assign result_valid = ctrl.emit;
    assign kind         = 3'(ctrl.kind);
    assign last         = ctrl.last;

endmodule
